// ----- sv/rrts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int NCELL = 32;
  localparam int IW    = $clog2(NCELL);
  localparam int CW    = $clog2(NCELL + 1);

  localparam logic [21:0] NOW_MAX   = 22'h3FFFFF;
  localparam logic [20:0] WSUM_MAX  = 21'h1FFFFF;

  localparam logic [1:0] K_LOAD  = 2'd0;
  localparam logic [1:0] K_RUN   = 2'd1;
  localparam logic [1:0] K_READ  = 2'd2;
  localparam logic [1:0] K_CLEAR = 2'd3;

  localparam logic [2:0] ST_LOADED = 3'd0;
  localparam logic [2:0] ST_SLICE  = 3'd1;
  localparam logic [2:0] ST_DONE   = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] arrival;
    logic [15:0] service;
    logic [15:0] remaining;
    logic [21:0] wait_t;
  } slot_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic        shift_in;    // cells rotate toward lower index (scan step)
    logic        ins;         // insert new entry
    logic [15:0] ins_arr;
    slot_t       ins_slot;
    logic        upd;         // cell 0 gets head_new
    slot_t       head_new;
  } cell_ctl_t;

endpackage

// ----- sv/rrts_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_if
// Valid/ready channels of the scheduler.
// ----------------------------------------------------------------------------
interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  pid;
  logic [15:0] arrival;
  logic [15:0] service;
  logic [4:0]  entry;
  modport source (output valid, kind, pid, arrival, service, entry, input ready);
  modport sink   (input valid, kind, pid, arrival, service, entry, output ready);
endinterface

interface rrts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  pid_res;
  logic [15:0] amount;
  logic        finished;
  logic [20:0] total_wait;
  logic [21:0] now;
  modport source (output valid, status, pid_res, amount, finished, total_wait, now,
                  input ready);
  modport sink   (input valid, status, pid_res, amount, finished, total_wait, now,
                  output ready);
endinterface

interface rrts_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/rrts_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_cell
// One table cell. The chain is a ring held in logical order starting at
// rotation offset: cell i holds logical entry (rot + i) mod count. Insertion
// is done in physical positions, so the sequencer first rotates the ring
// back to offset zero.
// ----------------------------------------------------------------------------
module rrts_cell
  import rrts_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      last,       // this cell is at position count-1 (ring wrap)
  input  logic      at_count,   // this cell is at position count
  input  slot_t     up_slot,    // from cell i+1
  input  slot_t     wrap_slot,  // cell 0, wraps into position count-1
  input  slot_t     dn_slot,    // from cell i-1
  input  logic      dn_gt,      // cell i-1 arrival > new arrival (and occupied)
  input  logic      occ,        // this cell below count
  input  logic      is_head,
  output slot_t     slot,
  output logic      gt          // occupied and arrival > insert arrival
);

  slot_t slot_r;
  logic  self_gt;

  assign self_gt = occ && (slot_r.arrival > ctl.ins_arr);
  assign gt      = self_gt;
  assign slot    = slot_r;

  // arrivals are sorted, so the first cell past the new arrival takes the
  // new entry and every cell after it takes its lower neighbor
  always_ff @(posedge clk) begin
    if (ctl.shift_in && occ) begin
      slot_r <= last ? wrap_slot : up_slot;
    end else if (ctl.ins) begin
      if (self_gt || at_count) begin
        if (dn_gt) begin
          slot_r <= dn_slot;        // shift up
        end else begin
          slot_r <= ctl.ins_slot;
        end
      end
    end else if (ctl.upd && is_head) begin
      slot_r <= ctl.head_new;
    end
  end

endmodule

// ----- sv/round_robin_time_slice_scheduler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler_top
// Round-robin scheduler over a ring of 32 process cells.
// ----------------------------------------------------------------------------
// One request at a time. The table is a ring of cells that rotates one
// position per cycle; the head cell is the one examined. A run request first
// rotates the ring to the scan start, then scans one entry per cycle over
// up to count entries, takes a second pass over up to count entries when
// time jumps over an idle gap (the gap minimum is gathered during the first
// pass), then passes through a grant state and an output state. A load
// first rotates the ring back to table order, then inserts. A read rotates
// until the entry is at the head; a clear goes straight to output. Results
// wait in an output register; the next request is taken once it is sent.
module round_robin_time_slice_scheduler_top
  import rrts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch,
  rrts_cfg_if.sink   cfg_ch
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ALIGN= 6'b000010,
    S_SCAN = 6'b000100,
    S_GRANT= 6'b001000,
    S_READ = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  st_t st_r;
  logic [15:0] quantum_r;
  logic [CW-1:0] count_r, pend_r;
  logic [IW-1:0] rot_r;          // logical index of cell 0
  logic [IW-1:0] scan_r;
  logic [21:0] now_r;
  logic [20:0] wsum_r;
  logic [CW-1:0] steps_r;
  logic        pass2_r;
  logic [16:0] earliest_r;       // bit16 = none
  logic [1:0]  kind_r;
  logic [7:0]  pid_r;
  logic [15:0] arr_r, svc_r;
  logic [4:0]  ent_r;

  logic        ov_r;
  logic [2:0]  o_st_r;
  logic [7:0]  o_pid_r;
  logic [15:0] o_amt_r;
  logic        o_fin_r;

  cell_ctl_t ctl;
  slot_t     slots [NCELL];
  logic      gts   [NCELL];
  slot_t     head;

  assign head = slots[0];
  assign in_ch.ready  = (st_r == S_IDLE) && !ov_r;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = ov_r;
  assign out_ch.status     = o_st_r;
  assign out_ch.pid_res    = o_pid_r;
  assign out_ch.amount     = o_amt_r;
  assign out_ch.finished   = o_fin_r;
  assign out_ch.total_wait = wsum_r;
  assign out_ch.now        = now_r;

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      localparam logic [CW-1:0] POS = CW'(gi);
      rrts_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .last     (POS == count_r - CW'(1)),
        .at_count (POS == count_r),
        .up_slot  (slots[(gi + 1) % NCELL]),
        .wrap_slot(slots[0]),
        .dn_slot  (slots[(gi + NCELL - 1) % NCELL]),
        .dn_gt    ((gi == 0) ? 1'b0 : gts[(gi + NCELL - 1) % NCELL]),
        .occ      (POS < count_r),
        .is_head  (gi == 0),
        .slot     (slots[gi]),
        .gt       (gts[gi])
      );
    end
  endgenerate

  // grant arithmetic on the head
  logic [15:0] q_eff, tr;
  logic [22:0] now_sum;
  logic [21:0] now_new;
  logic [16:0] used;
  logic [21:0] wnew;
  logic [22:0] wsum_sum;
  logic        ready_hd;
  logic [IW-1:0] hd_idx;
  logic [IW-1:0] scan_start;

  assign hd_idx     = rot_r;
  assign scan_start = (CW'(scan_r) < count_r) ? scan_r : '0;
  assign q_eff    = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign tr       = (head.remaining > q_eff) ? q_eff : head.remaining;
  assign now_sum  = {1'b0, now_r} + 23'(tr);
  assign now_new  = now_sum[22] ? NOW_MAX : now_sum[21:0];
  assign used     = {1'b0, head.arrival} + {1'b0, head.service};
  assign wnew     = (now_new > 22'(used)) ? now_new - 22'(used) : 22'd0;
  assign wsum_sum = {2'b00, wsum_r} + 23'(wnew);
  assign ready_hd = (head.remaining != 16'd0) && (22'(head.arrival) <= now_r);

  always_comb begin
    ctl = '0;
    ctl.ins_arr  = (count_r == '0) ? 16'd0 : arr_r;
    ctl.ins_slot.pid = pid_r;
    ctl.ins_slot.arrival = ctl.ins_arr;
    ctl.ins_slot.service = (svc_r == 16'd0) ? 16'd1 : svc_r;
    ctl.ins_slot.remaining = ctl.ins_slot.service;
    ctl.ins_slot.wait_t = 22'd0;
    ctl.head_new = head;
    ctl.head_new.remaining = head.remaining - tr;
    ctl.head_new.wait_t = wnew;
    case (st_r)
      S_ALIGN: begin
        if (kind_r == K_RUN) ctl.shift_in = (hd_idx != scan_start);
        else if (rot_r != '0) ctl.shift_in = 1'b1;
        else ctl.ins = 1'b1;
      end
      S_SCAN:  ctl.shift_in = !ready_hd && (steps_r != '0);
      S_READ:  ctl.shift_in = (hd_idx != ent_r[IW-1:0]);
      S_GRANT: ctl.upd = 1'b1;
      default: ;
    endcase
  end

  function automatic logic [IW-1:0] inc_mod(logic [IW-1:0] v, logic [CW-1:0] n);
    logic [CW:0] t;
    t = {1'b0, CW'(v)} + (CW+1)'(1);
    inc_mod = (t >= {1'b0, n}) ? '0 : t[IW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; quantum_r <= 16'd4; count_r <= '0; pend_r <= '0;
      rot_r <= '0; scan_r <= '0; now_r <= '0; wsum_r <= '0; ov_r <= 1'b0;
      steps_r <= '0; pass2_r <= 1'b0; earliest_r <= '0;
    end else begin
      if (cfg_ch.valid) quantum_r <= cfg_ch.data;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          kind_r <= in_ch.kind; pid_r <= in_ch.pid; arr_r <= in_ch.arrival;
          svc_r <= in_ch.service; ent_r <= in_ch.entry;
          o_st_r <= ST_LOADED; o_pid_r <= 8'd0; o_amt_r <= 16'd0; o_fin_r <= 1'b0;
          case (in_ch.kind)
            K_LOAD: begin
              if (count_r >= CW'(NCELL)) begin
                o_st_r <= ST_FULL; o_pid_r <= in_ch.pid; st_r <= S_OUT;
              end else st_r <= S_ALIGN;
            end
            K_RUN: begin
              if (pend_r == '0) begin
                o_st_r <= ST_DONE; st_r <= S_OUT;
              end else begin
                st_r <= S_ALIGN;  // rotate to scan start
                steps_r <= count_r; pass2_r <= 1'b0; earliest_r <= 17'h10000;
              end
            end
            K_READ: begin
              o_st_r <= ST_READ;
              if ({1'b0, in_ch.entry} < count_r) st_r <= S_READ;
              else st_r <= S_OUT;
            end
            default: begin
              count_r <= '0; pend_r <= '0; scan_r <= '0; rot_r <= '0;
              now_r <= '0; wsum_r <= '0; st_r <= S_OUT;
            end
          endcase
        end
        S_ALIGN: begin
          if (kind_r == K_RUN) begin
            // rotate until head is at the scan start
            if (hd_idx != scan_start) begin
              rot_r <= inc_mod(rot_r, count_r);
            end else st_r <= S_SCAN;
          end else if (rot_r != '0) begin
            rot_r <= inc_mod(rot_r, count_r);
          end else begin
            count_r <= count_r + CW'(1); pend_r <= pend_r + CW'(1);
            o_pid_r <= pid_r; st_r <= S_OUT;
          end
        end
        S_SCAN: begin
          if (ready_hd) st_r <= S_GRANT;
          else if (steps_r != '0) begin
            if (head.remaining != 16'd0 && {1'b0, head.arrival} < earliest_r)
              earliest_r <= {1'b0, head.arrival};
            steps_r <= steps_r - CW'(1);
            rot_r <= inc_mod(rot_r, count_r);
          end else if (!pass2_r) begin
            pass2_r <= 1'b0 | 1'b1; steps_r <= count_r;
            if (!earliest_r[16] && 22'(earliest_r[15:0]) > now_r)
              now_r <= 22'(earliest_r[15:0]);
          end else begin
            o_st_r <= ST_DONE; st_r <= S_OUT;
          end
        end
        S_GRANT: begin
          now_r <= now_new;
          o_st_r <= ST_SLICE; o_pid_r <= head.pid; o_amt_r <= tr;
          if (head.remaining == tr) begin
            o_fin_r <= 1'b1;
            wsum_r <= (wsum_sum > 23'(WSUM_MAX)) ? WSUM_MAX : wsum_sum[20:0];
            if (pend_r != '0) pend_r <= pend_r - CW'(1);
          end
          scan_r <= inc_mod(hd_idx, count_r);
          st_r <= S_OUT;
        end
        S_READ: begin
          if (hd_idx == ent_r[IW-1:0]) begin
            o_pid_r <= head.pid;
            o_amt_r <= (head.remaining != 16'd0) ? 16'd0 :
                       ((head.wait_t > 22'd65535) ? 16'hFFFF : head.wait_t[15:0]);
            st_r <= S_OUT;
          end else rot_r <= inc_mod(rot_r, count_r);
        end
        S_OUT: begin
          ov_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- test/round_robin_time_slice_scheduler_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler_top_tb
// Self-checking bench for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
// A short directed sequence covers empty runs, forced arrival, zero service,
// idle gaps and loads during a run. Randomized batches then load process
// sets, run them until none pends or 80 run-phase requests are sent, read
// back waiting times, mixed with noise requests, over several quantum
// settings and handshake idle mixes. A bench model predicts every response.
module round_robin_time_slice_scheduler_top_tb;
  import rrts_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  pid_res;
    logic [15:0] amount;
    logic        finished;
    logic [20:0] total_wait;
    logic [21:0] now;
  } sched_resp_t;

  class sched_scoreboard;
    logic [7:0]  pid_tab[NCELL];
    int unsigned arr_tab[NCELL];
    int unsigned svc_tab[NCELL];
    int unsigned rem_tab[NCELL];
    int unsigned wait_tab[NCELL];
    int unsigned n_entries, n_pending, scan_pos, cur_time, wait_total, quantum;
    sched_resp_t resp_q[$];
    int errors, n_slices, n_finished, n_full, n_done, n_read;

    function new();
      n_entries = 0; n_pending = 0; scan_pos = 0; cur_time = 0; wait_total = 0;
      quantum = 4; errors = 0;
      n_slices = 0; n_finished = 0; n_full = 0; n_done = 0; n_read = 0;
    endfunction

    function int find_ready();
      int unsigned start, idx;
      start = (scan_pos < n_entries) ? scan_pos : 0;
      for (int unsigned k = 0; k < n_entries; k++) begin
        idx = start + k;
        if (idx >= n_entries) idx -= n_entries;
        if (rem_tab[idx] > 0 && arr_tab[idx] <= cur_time) return idx;
      end
      return -1;
    endfunction

    function void push(logic [2:0] st, logic [7:0] p, int unsigned amt, bit fin);
      sched_resp_t r;
      r.status = st; r.pid_res = p; r.amount = amt[15:0]; r.finished = fin;
      r.total_wait = wait_total[20:0]; r.now = cur_time[21:0];
      resp_q.push_back(r);
    endfunction

    function void grant_slice();
      int found;
      int unsigned earliest, q, tr, used;
      bit fin;
      fin = 0;
      if (n_pending == 0) begin
        push(ST_DONE, 0, 0, 0);
        return;
      end
      found = find_ready();
      if (found < 0) begin
        earliest = 32'hFFFF_FFFF;
        for (int unsigned k = 0; k < n_entries; k++)
          if (rem_tab[k] > 0 && arr_tab[k] < earliest) earliest = arr_tab[k];
        if (earliest > cur_time) cur_time = earliest;
        found = find_ready();
        if (found < 0) begin
          push(ST_DONE, 0, 0, 0);
          return;
        end
      end
      q = (quantum == 0) ? 1 : quantum;
      tr = (rem_tab[found] > q) ? q : rem_tab[found];
      rem_tab[found] -= tr;
      cur_time += tr;
      if (cur_time > NOW_MAX) cur_time = NOW_MAX;
      if (rem_tab[found] == 0) begin
        fin = 1;
        used = arr_tab[found] + svc_tab[found];
        wait_tab[found] = (cur_time > used) ? cur_time - used : 0;
        wait_total += wait_tab[found];
        if (wait_total > WSUM_MAX) wait_total = WSUM_MAX;
        if (n_pending > 0) n_pending--;
        n_finished++;
      end
      scan_pos = (found + 1 < n_entries) ? found + 1 : 0;
      n_slices++;
      push(ST_SLICE, pid_tab[found], tr, fin);
    endfunction

    // accepted request: update the model and queue the expected response
    function void note_request(logic [1:0] kind, logic [7:0] pid, logic [15:0] arr,
                               logic [15:0] svc, logic [4:0] ent);
      int unsigned pos, a, s, w;
      case (kind)
        K_LOAD: begin
          if (n_entries >= NCELL) begin
            n_full++;
            push(ST_FULL, pid, 0, 0);
          end else begin
            a = (n_entries == 0) ? 0 : arr;
            s = (svc == 0) ? 1 : svc;
            pos = n_entries;
            while (pos > 0 && arr_tab[pos-1] > a) begin
              pid_tab[pos] = pid_tab[pos-1]; arr_tab[pos] = arr_tab[pos-1];
              svc_tab[pos] = svc_tab[pos-1]; rem_tab[pos] = rem_tab[pos-1];
              wait_tab[pos] = wait_tab[pos-1];
              pos--;
            end
            pid_tab[pos] = pid; arr_tab[pos] = a; svc_tab[pos] = s;
            rem_tab[pos] = s; wait_tab[pos] = 0;
            n_entries++; n_pending++;
            push(ST_LOADED, pid, 0, 0);
          end
        end
        K_RUN: begin
          if (n_pending == 0) n_done++;
          grant_slice();
        end
        K_READ: begin
          n_read++;
          if (ent < n_entries) begin
            w = (wait_tab[ent] > 65535) ? 65535 : wait_tab[ent];
            push(ST_READ, pid_tab[ent], w, 0);
          end else push(ST_READ, 0, 0, 0);
        end
        default: begin
          n_entries = 0; n_pending = 0; scan_pos = 0; cur_time = 0; wait_total = 0;
          push(ST_LOADED, 0, 0, 0);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_response(sched_resp_t got);
      sched_resp_t e;
      if (resp_q.size() == 0) begin
        report($sformatf("unexpected response status=%0d", got.status));
        return;
      end
      e = resp_q.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, expected %0d", got.status, e.status));
      if (got.pid_res !== e.pid_res)
        report($sformatf("pid_res %0h, expected %0h", got.pid_res, e.pid_res));
      if (got.amount !== e.amount)
        report($sformatf("amount %0d, expected %0d", got.amount, e.amount));
      if (got.finished !== e.finished)
        report($sformatf("finished %0b, expected %0b", got.finished, e.finished));
      if (got.total_wait !== e.total_wait)
        report($sformatf("total_wait %0d, expected %0d", got.total_wait, e.total_wait));
      if (got.now !== e.now)
        report($sformatf("now %0d, expected %0d", got.now, e.now));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  rrts_in_if  in_ch ();
  rrts_out_if out_ch ();
  rrts_cfg_if cfg_ch ();

  round_robin_time_slice_scheduler_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sched_scoreboard sb = new();
  int send_idle = 8;
  int recv_idle = 58;
  int n_requests = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 3000000;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** round_robin_time_slice_scheduler_top: FAILED **");
      $finish;
    end
  end

  // response monitor
  always @(posedge clk) begin
    sched_resp_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.status = out_ch.status; r.pid_res = out_ch.pid_res; r.amount = out_ch.amount;
      r.finished = out_ch.finished; r.total_wait = out_ch.total_wait; r.now = out_ch.now;
      sb.check_response(r);
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_ch.ready = ($urandom_range(99) >= recv_idle);

  task send_request(logic [1:0] kind, logic [7:0] pid, logic [15:0] arr,
                    logic [15:0] svc, logic [4:0] ent);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1; in_ch.kind = kind; in_ch.pid = pid;
    in_ch.arrival = arr; in_ch.service = svc; in_ch.entry = ent;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(kind, pid, arr, svc, ent);
    n_requests++;
  endtask

  task drain();
    @(negedge clk);
    in_ch.valid = 0;
    while (sb.resp_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task write_quantum(logic [15:0] q);
    drain();
    cfg_ch.valid = 1; cfg_ch.data = q;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.quantum = q;
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  function logic [15:0] pick_service();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 12));
    if (sb.quantum >= 1000 || sb.quantum == 0) return 16'($urandom_range(1, 65535));
    return 16'($urandom_range(1, 40));
  endfunction

  // one process set: load, run until none pends (at most 80 requests), read back; or a burst of noise
  task process_batch();
    int nload, runs;
    bit wide_arr;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 6))
        send_request(2'($urandom_range(3)), 8'($urandom), 16'($urandom),
                     16'($urandom), 5'($urandom));
      return;
    end
    if ($urandom_range(99) < 60)
      send_request(K_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
    nload = ($urandom_range(99) < 15) ? $urandom_range(30, 34) : $urandom_range(1, 10);
    wide_arr = ($urandom_range(99) < 20);
    repeat (nload)
      send_request(K_LOAD, 8'($urandom),
                   wide_arr ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 60)),
                   pick_service(), 5'($urandom));
    runs = 0;
    while (sb.n_pending != 0 && runs < 80) begin
      case ($urandom_range(19))
        0: send_request(K_LOAD, 8'($urandom), 16'($urandom_range(0, 200)),
                        pick_service(), 5'($urandom));
        1: send_request(K_READ, 8'($urandom), 16'($urandom), 16'($urandom),
                        5'($urandom_range(0, 31)));
        default: send_request(K_RUN, 8'($urandom), 16'($urandom), 16'($urandom),
                              5'($urandom));
      endcase
      runs++;
    end
    send_request(K_RUN, 8'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
    repeat ($urandom_range(1, 5))
      send_request(K_READ, 8'($urandom), 16'($urandom), 16'($urandom),
                   5'($urandom_range(0, 31)));
  endtask

  task random_phase(int target);
    int stop_at;
    bit paused;
    stop_at = n_requests + target;
    paused = 0;
    while (n_requests < stop_at) begin
      process_batch();
      if (!paused && n_requests > stop_at - target / 2) begin
        drain();  // hold off until every response is back
        paused = 1;
      end
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.kind = K_LOAD; in_ch.pid = 0; in_ch.arrival = 0;
    in_ch.service = 0; in_ch.entry = 0;
    cfg_ch.valid = 0; cfg_ch.data = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed
    send_request(K_CLEAR, 0, 0, 0, 0);
    send_request(K_RUN, 0, 0, 0, 0);              // nothing pending
    send_request(K_READ, 0, 0, 0, 5'd31);         // out of range
    send_request(K_LOAD, 8'hFF, 16'hFFFF, 16'h0000, 5'd0); // arrival forced, zero service
    send_request(K_LOAD, 8'h00, 16'hFFFF, 16'hFFFF, 5'h1F);
    send_request(K_LOAD, 8'hAA, 16'd100, 16'd5, 0);
    send_request(K_LOAD, 8'h55, 16'd100, 16'd3, 0); // equal arrival keeps order
    repeat (4) send_request(K_RUN, 0, 0, 0, 0);    // includes an idle gap jump
    send_request(K_LOAD, 8'h33, 16'd0, 16'd3, 0);  // insert during a run
    repeat (4) send_request(K_RUN, 0, 0, 0, 0);
    send_request(K_READ, 0, 0, 0, 5'd0);
    send_request(K_READ, 0, 0, 0, 5'd1);
    send_request(K_READ, 0, 0, 0, 5'd2);
    send_request(K_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 5'h1F);
    send_request(K_RUN, 0, 0, 0, 0);

    send_idle = 8; recv_idle = 58;
    write_quantum(16'd1);
    random_phase(200);
    write_quantum(16'hFFFF);
    random_phase(250);
    send_idle = 58; recv_idle = 8;
    write_quantum(16'd0);
    random_phase(200);
    write_quantum(16'($urandom_range(2, 30)));
    random_phase(250);
    send_idle = 0; recv_idle = 0;
    write_quantum(16'($urandom_range(1000, 65535)));
    random_phase(200);
    write_quantum(16'd4);
    random_phase(250);

    drain();
    $display("%0d requests: %0d slices, %0d completions, %0d empty runs, %0d full, %0d reads",
             n_requests, sb.n_slices, sb.n_finished, sb.n_done, sb.n_full, sb.n_read);
    $display("quantum settings 0, 1, 4, 65535 and random; %0d mismatches", sb.errors);
    if (sb.errors == 0)
      $display("** round_robin_time_slice_scheduler_top: PASSED **");
    else
      $display("** round_robin_time_slice_scheduler_top: FAILED **");
    $finish;
  end

endmodule
